// File: rtl/core/fspa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspa_pkg
// Shared types and constants for the fixed slot pool allocator.
// ----------------------------------------------------------------------------
package fspa_pkg;

  localparam int MAX_PAGES_DEF      = 16;
  localparam int MAX_SPP_DEF        = 511;
  localparam int PAGE_STRIDE_LOG2   = 9;
  localparam int HANDLE_W           = 13;
  localparam int COUNT_W            = 13;
  localparam int PAGE_W             = 5;
  localparam int SPP_W              = 9;
  localparam int FAIL_W             = 32;
  localparam int STATUS_W           = 3;
  localparam int CAP_W              = 16;

  localparam logic [1:0] REQ_INIT    = 2'd0;
  localparam logic [1:0] REQ_ALLOC   = 2'd1;
  localparam logic [1:0] REQ_FREE    = 2'd2;
  localparam logic [1:0] REQ_DESTROY = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_ALIVE = 3'd1;
  localparam logic [2:0] ST_NO_PAGES  = 3'd2;
  localparam logic [2:0] ST_LIVE      = 3'd3;
  localparam logic [2:0] ST_BAD_FREE  = 3'd4;

  localparam logic CFG_SPP    = 1'b0;
  localparam logic CFG_BUDGET = 1'b1;

  // request from sequencer to the page-link walker
  typedef struct packed {
    logic                start;
    logic [PAGE_W-1:0]   page;
    logic [SPP_W-1:0]    spp;
    logic [HANDLE_W:0]   old_head;
  } fspa_walk_req_t;

endpackage

// File: rtl/core/fspa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fspa_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/fspa_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspa_divider
// Restoring divider, one quotient bit per cycle: ceil(cap / spp).
// ----------------------------------------------------------------------------
module fspa_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [fspa_pkg::CAP_W-1:0]     cap,
  input  logic [fspa_pkg::SPP_W-1:0]     spp,
  output logic                           done,
  output logic [fspa_pkg::CAP_W:0]       quot
);

  localparam int N = fspa_pkg::CAP_W + 1;

  logic [N-1:0]               num_r, num_nxt;
  logic [N-1:0]               q_r, q_nxt;
  logic [fspa_pkg::SPP_W:0]   rem_r, rem_nxt;
  logic [fspa_pkg::SPP_W:0]   trial;
  logic [4:0]                 cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;

  always_comb begin
    num_nxt  = num_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (start) begin
      // numerator cap + spp - 1 for ceiling
      num_nxt  = N'(cap) + N'(spp) - N'(1);
      q_nxt    = '0;
      rem_nxt  = '0;
      cnt_nxt  = 5'(N);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial   = {rem_r[fspa_pkg::SPP_W-1:0], num_r[N-1]};
      num_nxt = {num_r[N-2:0], 1'b0};
      if (trial >= {1'b0, spp}) begin
        rem_nxt = trial - {1'b0, spp};
        q_nxt   = {q_r[N-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[N-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// File: rtl/core/fspa_page_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspa_page_walker
// Links the slots of one new page, one link write per cycle.
// ----------------------------------------------------------------------------
module fspa_page_walker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fspa_pkg::fspa_walk_req_t         req,
  output logic                             busy,
  output logic                             done,
  output logic                             we,
  output logic [fspa_pkg::HANDLE_W-1:0]    waddr,
  output logic [fspa_pkg::HANDLE_W:0]      wdata
);

  logic [fspa_pkg::SPP_W-1:0]    idx_r, idx_nxt;
  logic [fspa_pkg::SPP_W-1:0]    spp_r, spp_nxt;
  logic [fspa_pkg::PAGE_W-1:0]   page_r, page_nxt;
  logic [fspa_pkg::HANDLE_W:0]   head_r, head_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [fspa_pkg::HANDLE_W-1:0] h;

  assign h = {page_r[fspa_pkg::HANDLE_W-fspa_pkg::PAGE_STRIDE_LOG2-1:0], idx_r};

  always_comb begin
    idx_nxt  = idx_r;
    spp_nxt  = spp_r;
    page_nxt = page_r;
    head_nxt = head_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      idx_nxt  = '0;
      spp_nxt  = req.spp;
      page_nxt = req.page;
      head_nxt = req.old_head;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      idx_nxt = idx_r + 1'b1;
      if (idx_r == spp_r - 1'b1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    idx_r  <= idx_nxt;
    spp_r  <= spp_nxt;
    page_r <= page_nxt;
    head_r <= head_nxt;
  end

  assign busy  = busy_r;
  assign done  = done_r;
  assign we    = busy_r;
  assign waddr = h;
  // slot 0 links to the old head, others to the slot below
  assign wdata = (idx_r == '0) ? head_r : {1'b0, h - 1'b1};

endmodule

// File: rtl/core/fixed_slot_pool_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator_core
// Free-list slab allocator over a link RAM that grows one page at a time.
// ----------------------------------------------------------------------------
// One transaction at a time. Each step waits on the registered link RAM read
// and the single link RAM write port. Allocate from a nonempty list passes
// S_POP_RD, S_POP_WR and S_OUT; any free passes S_FREE_RD, S_FREE_CHK and
// S_OUT. A request that is answered at once (dead pool, live slots on destroy,
// failed grow, destroy, init with zero slots per page) goes straight to S_OUT.
// Growing a page takes a launch in S_GROW, one link write per slot and a done
// strobe from the walker. Init runs a serial divide for
// ceil(capacity/slots_per_page) and the budget check, then grows each page
// attached. The result is held in an output register until taken. The link RAM
// needs no clearing; allocated marks are a second RAM, checked on free together
// with the page and slot bounds: a page's marks are cleared by its walk.
module fixed_slot_pool_allocator_core #(
  parameter int MAX_SLOTS_PER_PAGE = fspa_pkg::MAX_SPP_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_req_type,
  input  logic [fspa_pkg::CAP_W-1:0]        in_capacity,
  input  logic [fspa_pkg::HANDLE_W-1:0]     in_slot_handle,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fspa_pkg::STATUS_W-1:0]     out_status,
  output logic [fspa_pkg::HANDLE_W-1:0]     out_granted_handle,
  output logic [fspa_pkg::COUNT_W-1:0]      out_total_slots,
  output logic [fspa_pkg::COUNT_W-1:0]      out_used_slots,
  output logic [fspa_pkg::COUNT_W-1:0]      out_peak_used,
  output logic [fspa_pkg::PAGE_W-1:0]       out_pages_attached,
  output logic [fspa_pkg::FAIL_W-1:0]       out_failed_grow_count,
  output logic                              out_pool_alive,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [8:0]                        cfg_data
);

  localparam int MAX_PAGES = fspa_pkg::MAX_PAGES_DEF;
  localparam int HW    = fspa_pkg::HANDLE_W;
  localparam int DEPTH = MAX_PAGES * 512;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [HW:0] LINK_NULL = {1'b1, {HW{1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_GO, S_DIV, S_CHECK, S_GROW, S_WALK, S_POP_RD, S_POP_WR,
    S_FREE_RD, S_FREE_CHK, S_OUT
  } state_t;

  state_t state_r;

  logic [fspa_pkg::SPP_W-1:0]  cfg_spp_r;
  logic [fspa_pkg::PAGE_W-1:0] cfg_budget_r;
  logic [HW-1:0]               hnd_r;
  logic [HW:0]                 head_r;
  logic                        alive_r;
  logic [fspa_pkg::COUNT_W-1:0] total_r, used_r, peak_r;
  logic [fspa_pkg::PAGE_W-1:0] pages_r;
  logic [fspa_pkg::FAIL_W-1:0] fail_r;
  logic [fspa_pkg::SPP_W-1:0]  spp_r;
  logic [fspa_pkg::CAP_W:0]    need_r;
  logic                        after_pop_r;
  logic [fspa_pkg::STATUS_W-1:0] st_r;
  logic [HW-1:0]               grant_r;

  logic [fspa_pkg::SPP_W-1:0]  spp_sat;
  logic [fspa_pkg::PAGE_W-1:0] budget;

  assign spp_sat = (cfg_spp_r > fspa_pkg::SPP_W'(MAX_SLOTS_PER_PAGE))
                   ? fspa_pkg::SPP_W'(MAX_SLOTS_PER_PAGE) : cfg_spp_r;
  assign budget  = (cfg_budget_r > fspa_pkg::PAGE_W'(MAX_PAGES))
                   ? fspa_pkg::PAGE_W'(MAX_PAGES) : cfg_budget_r;

  // divider
  logic                       div_start, div_done;
  logic [fspa_pkg::CAP_W:0]   div_q;
  logic [fspa_pkg::CAP_W-1:0] cap_r;

  fspa_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .cap(cap_r), .spp(spp_r),
    .done(div_done), .quot(div_q)
  );

  // page walker
  fspa_pkg::fspa_walk_req_t walk_req;
  logic          walk_busy, walk_done, walk_we;
  logic [HW-1:0] walk_addr;
  logic [HW:0]   walk_data;

  fspa_page_walker u_walk (
    .clk(clk), .rst_n(rst_n), .req(walk_req), .busy(walk_busy),
    .done(walk_done), .we(walk_we), .waddr(walk_addr), .wdata(walk_data)
  );

  // link RAM and allocated-mark RAM
  logic          link_we, mark_we, mark_wd, mark_rd;
  logic [AW-1:0] link_wa, link_ra;
  logic [HW:0]   link_wd, link_rd;
  logic          st_free_bad;

  fspa_ram #(.WIDTH(HW + 1), .DEPTH(DEPTH)) u_link (
    .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
    .raddr(link_ra), .rdata(link_rd)
  );

  fspa_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_mark (
    .clk(clk), .we(mark_we), .waddr(link_wa), .wdata(mark_wd),
    .raddr(link_ra), .rdata(mark_rd)
  );

  logic [HW-1:0] pop_h;
  assign pop_h = head_r[HW-1:0];

  always_comb begin
    link_we = 1'b0;
    mark_we = 1'b0;
    mark_wd = 1'b0;
    link_wa = AW'(walk_addr);
    link_wd = walk_data;
    link_ra = AW'(hnd_r);
    if (walk_we) begin
      link_we = 1'b1;
      mark_we = 1'b1;
    end else if (state_r == S_POP_WR) begin
      link_wa = AW'(pop_h);
      mark_we = 1'b1;
      mark_wd = 1'b1;
    end else if (state_r == S_FREE_CHK) begin
      link_wa = AW'(hnd_r);
      link_wd = head_r;
      mark_wd = 1'b0;
    end
    if (state_r == S_POP_RD || state_r == S_GROW || state_r == S_WALK) begin
      link_ra = AW'(pop_h);
    end
    if (state_r == S_FREE_CHK && !(st_free_bad)) begin
      link_we = 1'b1;
      mark_we = 1'b1;
    end
  end

  logic [fspa_pkg::PAGE_W-1:0] hnd_pg;
  assign hnd_pg = fspa_pkg::PAGE_W'(hnd_r >> fspa_pkg::PAGE_STRIDE_LOG2);
  assign st_free_bad = !alive_r || used_r == '0
                       || {1'b0, hnd_pg} >= {1'b0, pages_r}
                       || hnd_r[8:0] >= spp_r
                       || 32'(hnd_r) >= 32'(DEPTH) || !mark_rd;

  always_comb begin
    walk_req          = '0;
    walk_req.page     = pages_r;
    walk_req.spp      = spp_r;
    walk_req.old_head = head_r;
    walk_req.start    = (state_r == S_GROW);
  end

  // divider launches once capacity and slots per page sit in registers
  assign div_start = (state_r == S_DIV_GO);
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_spp_r    <= 9'd511;
      cfg_budget_r <= 5'd16;
      head_r       <= LINK_NULL;
      alive_r      <= 1'b0;
      total_r      <= '0;
      used_r       <= '0;
      peak_r       <= '0;
      pages_r      <= '0;
      fail_r       <= '0;
      spp_r        <= '0;
      after_pop_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          fspa_pkg::CFG_SPP:    cfg_spp_r <= cfg_data;
          fspa_pkg::CFG_BUDGET: cfg_budget_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            hnd_r   <= in_slot_handle;
            cap_r   <= in_capacity;
            st_r    <= fspa_pkg::ST_OK;
            grant_r <= '0;
            case (in_req_type)
              fspa_pkg::REQ_INIT: begin
                head_r  <= LINK_NULL;
                alive_r <= 1'b0;
                total_r <= '0;
                used_r  <= '0;
                peak_r  <= '0;
                pages_r <= '0;
                fail_r  <= '0;
                spp_r   <= spp_sat;
                if (spp_sat == '0) begin
                  st_r    <= fspa_pkg::ST_NO_PAGES;
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_DIV_GO;
                end
              end
              fspa_pkg::REQ_ALLOC: begin
                if (!alive_r) begin
                  st_r    <= fspa_pkg::ST_NOT_ALIVE;
                  state_r <= S_OUT;
                end else if (head_r != LINK_NULL) begin
                  state_r <= S_POP_RD;
                end else if (pages_r < budget && spp_r != '0) begin
                  after_pop_r <= 1'b1;
                  state_r     <= S_GROW;
                end else begin
                  fail_r  <= fail_r + 1'b1;
                  st_r    <= fspa_pkg::ST_NO_PAGES;
                  state_r <= S_OUT;
                end
              end
              fspa_pkg::REQ_FREE: state_r <= S_FREE_RD;
              default: begin
                if (!alive_r) begin
                  st_r <= fspa_pkg::ST_NOT_ALIVE;
                end else if (used_r != '0) begin
                  st_r <= fspa_pkg::ST_LIVE;
                end else begin
                  head_r  <= LINK_NULL;
                  alive_r <= 1'b0;
                  total_r <= '0;
                  peak_r  <= '0;
                  pages_r <= '0;
                  fail_r  <= '0;
                  spp_r   <= '0;
                end
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_DIV_GO: state_r <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            need_r  <= (div_q == '0) ? 17'd1 : div_q;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (need_r > 17'(budget)) begin
            st_r    <= fspa_pkg::ST_NO_PAGES;
            spp_r   <= '0;
            state_r <= S_OUT;
          end else begin
            after_pop_r <= 1'b0;
            state_r     <= S_GROW;
          end
        end
        S_GROW: state_r <= S_WALK;
        S_WALK: begin
          if (walk_done) begin
            head_r  <= {1'b0, pages_r[HW-9-1:0], spp_r - 1'b1};
            total_r <= total_r + fspa_pkg::COUNT_W'(spp_r);
            pages_r <= pages_r + 1'b1;
            if (after_pop_r) begin
              state_r <= S_POP_RD;
            end else if (17'(pages_r) + 17'd1 < need_r) begin
              state_r <= S_GROW;
            end else begin
              alive_r <= 1'b1;
              state_r <= S_OUT;
            end
          end
        end
        S_POP_RD: state_r <= S_POP_WR;
        S_POP_WR: begin
          grant_r <= pop_h;
          head_r  <= link_rd;
          used_r  <= used_r + 1'b1;
          if (used_r + 1'b1 > peak_r) begin
            peak_r <= used_r + 1'b1;
          end
          state_r <= S_OUT;
        end
        S_FREE_RD: state_r <= S_FREE_CHK;
        S_FREE_CHK: begin
          if (st_free_bad) begin
            st_r <= fspa_pkg::ST_BAD_FREE;
          end else begin
            head_r <= {1'b0, hnd_r};
            used_r <= used_r - 1'b1;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid             = (state_r == S_OUT);
  assign out_status            = st_r;
  assign out_granted_handle    = grant_r;
  assign out_total_slots       = total_r;
  assign out_used_slots        = used_r;
  assign out_peak_used         = peak_r;
  assign out_pages_attached    = pages_r;
  assign out_failed_grow_count = fail_r;
  assign out_pool_alive        = alive_r;

  a_used_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_used_slots <= out_total_slots)
    else $error("used exceeds total");
  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_peak_used >= out_used_slots)
    else $error("peak below used");
  a_dead_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pool_alive) |-> out_used_slots == '0)
    else $error("dead pool with used slots");
  a_walk_state: assert property (@(posedge clk) disable iff (!rst_n)
    walk_busy |-> state_r == S_WALK)
    else $error("link walk outside walk state");

endmodule

// File: dv/tb_fixed_slot_pool_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_slot_pool_allocator_core
// Self-checking bench for the slot pool allocator: a free-list predictor runs
// beside the core and every result transaction is compared field by field.
// ----------------------------------------------------------------------------
module tb_fixed_slot_pool_allocator_core;

  localparam int NHANDLES = fspa_pkg::MAX_PAGES_DEF * 512;
  localparam logic [13:0] LINK_NIL = 14'h2000;
  localparam int STALL_LIMIT = 40000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0]                    req;
    logic [fspa_pkg::CAP_W-1:0]    cap;
    logic [fspa_pkg::HANDLE_W-1:0] hnd;
  } pool_req_t;

  typedef struct packed {
    logic [fspa_pkg::STATUS_W-1:0] status;
    logic [fspa_pkg::HANDLE_W-1:0] granted;
    logic [fspa_pkg::COUNT_W-1:0]  total;
    logic [fspa_pkg::COUNT_W-1:0]  used;
    logic [fspa_pkg::COUNT_W-1:0]  peak;
    logic [fspa_pkg::PAGE_W-1:0]   pages;
    logic [fspa_pkg::FAIL_W-1:0]   fails;
    logic                          alive;
  } pool_rsp_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready, cfg_index;
  logic [1:0] in_req_type;
  logic [fspa_pkg::CAP_W-1:0] in_capacity;
  logic [fspa_pkg::HANDLE_W-1:0] in_slot_handle;
  logic [8:0] cfg_data;
  logic [fspa_pkg::STATUS_W-1:0] out_status;
  logic [fspa_pkg::HANDLE_W-1:0] out_granted_handle;
  logic [fspa_pkg::COUNT_W-1:0] out_total_slots, out_used_slots, out_peak_used;
  logic [fspa_pkg::PAGE_W-1:0] out_pages_attached;
  logic [fspa_pkg::FAIL_W-1:0] out_failed_grow_count;
  logic out_pool_alive;

  fixed_slot_pool_allocator_core dut (.*);

  // predictor state
  logic [13:0] p_link [NHANDLES];
  bit          p_taken [NHANDLES];
  logic [13:0] p_head = LINK_NIL;
  bit          p_alive;
  int unsigned p_total, p_used, p_peak, p_pages, p_spp, p_fails;
  int unsigned r_spp, r_budget;

  pool_req_t req_q[$];
  pool_rsp_t rsp_q[$];
  int errors, n_in, n_out, idle_cnt;
  bit no_idle, done, start_hold, hold_rx;

  function automatic void pool_clear();
    p_head = LINK_NIL; p_alive = 0; p_total = 0; p_used = 0; p_peak = 0;
    p_pages = 0; p_fails = 0; p_spp = 0;
    foreach (p_taken[i]) p_taken[i] = 0;
  endfunction

  function automatic void pool_attach();
    int unsigned base;
    base = p_pages * 512;
    for (int unsigned i = 0; i < p_spp; i++)
      p_link[base + i] = (i == 0) ? p_head : 14'(base + i - 1);
    p_head = 14'(base + p_spp - 1);
    p_total += p_spp;
    p_pages++;
  endfunction

  function automatic logic [12:0] pool_pop();
    logic [12:0] h;
    h = p_head[12:0];
    p_head = p_link[h];
    p_taken[h] = 1;
    p_used++;
    if (p_used > p_peak) p_peak = p_used;
    return h;
  endfunction

  function automatic pool_rsp_t pool_apply(pool_req_t r);
    pool_rsp_t o;
    int unsigned budget, spp, need, pg, sl;
    o = '0;
    budget = (r_budget > fspa_pkg::MAX_PAGES_DEF) ? fspa_pkg::MAX_PAGES_DEF : r_budget;
    case (r.req)
      fspa_pkg::REQ_INIT: begin
        spp = r_spp;
        pool_clear();
        if (spp == 0) o.status = fspa_pkg::ST_NO_PAGES;
        else begin
          need = (r.cap + spp - 1) / spp;
          if (need == 0) need = 1;
          if (need > budget) o.status = fspa_pkg::ST_NO_PAGES;
          else begin
            p_spp = spp;
            while (p_pages < need) pool_attach();
            p_alive = 1;
          end
        end
      end
      fspa_pkg::REQ_ALLOC: begin
        if (!p_alive) o.status = fspa_pkg::ST_NOT_ALIVE;
        else if (p_head != LINK_NIL) o.granted = pool_pop();
        else if (p_pages < budget && p_spp != 0) begin
          pool_attach();
          o.granted = pool_pop();
        end else begin
          p_fails++;
          o.status = fspa_pkg::ST_NO_PAGES;
        end
      end
      fspa_pkg::REQ_FREE: begin
        pg = r.hnd / 512; sl = r.hnd % 512;
        if (!p_alive || p_used == 0 || pg >= p_pages || sl >= p_spp || !p_taken[r.hnd])
          o.status = fspa_pkg::ST_BAD_FREE;
        else begin
          p_link[r.hnd] = p_head;
          p_head = {1'b0, r.hnd};
          p_taken[r.hnd] = 0;
          p_used--;
        end
      end
      default: begin
        if (!p_alive) o.status = fspa_pkg::ST_NOT_ALIVE;
        else if (p_used != 0) o.status = fspa_pkg::ST_LIVE;
        else pool_clear();
      end
    endcase
    o.total = fspa_pkg::COUNT_W'(p_total);
    o.used  = fspa_pkg::COUNT_W'(p_used);
    o.peak  = fspa_pkg::COUNT_W'(p_peak);
    o.pages = fspa_pkg::PAGE_W'(p_pages);
    o.fails = p_fails;
    o.alive = p_alive;
    return o;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_req_type <= '0;
      in_capacity <= '0;
      in_slot_handle <= '0;
    end else begin
      if (in_valid && in_ready) begin
        rsp_q.push_back(pool_apply(req_q.pop_front()));
        n_in++;
      end
      if ((!in_valid || in_ready) && req_q.size() > 0 &&
          (no_idle || $urandom_range(99) >= 8)) begin
        in_valid <= 1;
        in_req_type <= req_q[0].req;
        in_capacity <= req_q[0].cap;
        in_slot_handle <= req_q[0].hnd;
      end else if (in_valid && in_ready) begin
        in_valid <= 0;
      end
    end
  end

  // receiver hold-off, counted here while the sender keeps offering
  initial begin
    wait (start_hold);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // monitor and receiver
  always @(posedge clk) begin
    pool_rsp_t got, exp;
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_out++;
        got = '{out_status, out_granted_handle, out_total_slots, out_used_slots,
                out_peak_used, out_pages_attached, out_failed_grow_count, out_pool_alive};
        if (rsp_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected result transaction %p", got);
        end else begin
          exp = rsp_q.pop_front();
          if (got !== exp) begin
            errors++;
            if (errors <= 10) $display("ERROR: result %0d expected %p got %p", n_out, exp, got);
          end
        end
      end
      if (hold_rx) out_ready <= 0;
      else out_ready <= no_idle || $urandom_range(99) >= 8;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || done) idle_cnt <= 0;
    else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", idle_cnt);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic push_req(logic [1:0] t, int c, int h);
    req_q.push_back('{t, c[15:0], h[12:0]});
  endtask

  task automatic drain();
    while (req_q.size() > 0 || in_valid || rsp_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v[8:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == fspa_pkg::CFG_SPP) r_spp = v & 'h1FF;
    else r_budget = v & 'h1F;
  endtask

  // random phase: mostly alloc and free of low slots, some noise
  task automatic random_phase(int n);
    int k, c;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 3) begin
        c = ($urandom_range(3) == 0) ? $urandom : $urandom_range(r_spp * 3 + 2);
        push_req(fspa_pkg::REQ_INIT, c, $urandom);
      end else if (k < 6) push_req(fspa_pkg::REQ_DESTROY, $urandom, $urandom);
      else if (k < 50) push_req(fspa_pkg::REQ_ALLOC, $urandom, $urandom);
      else if (k < 90)
        push_req(fspa_pkg::REQ_FREE, $urandom,
                 int'($urandom_range(3) * 512 + $urandom_range(12)));
      else push_req(fspa_pkg::REQ_FREE, $urandom, $urandom);
    end
  endtask

  initial begin
    rst_n = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    r_spp = 511; r_budget = 16;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: dead pool, extremes, bad frees, growth, budget exhaustion
    push_req(fspa_pkg::REQ_ALLOC, 0, 0);
    push_req(fspa_pkg::REQ_DESTROY, 0, 0);
    push_req(fspa_pkg::REQ_FREE, 0, 8191);
    push_req(fspa_pkg::REQ_INIT, 65535, 0);          // too many pages
    push_req(fspa_pkg::REQ_INIT, 0, 0);              // minimum one page
    push_req(fspa_pkg::REQ_ALLOC, 0, 0);
    push_req(fspa_pkg::REQ_FREE, 0, 510);
    push_req(fspa_pkg::REQ_FREE, 0, 510);            // double free
    push_req(fspa_pkg::REQ_ALLOC, 0, 0);
    push_req(fspa_pkg::REQ_DESTROY, 0, 0);           // live slots
    push_req(fspa_pkg::REQ_FREE, 0, 8191);           // out-of-range page
    push_req(fspa_pkg::REQ_FREE, 0, 511);            // slot past spp
    push_req(fspa_pkg::REQ_FREE, 0, 510);
    push_req(fspa_pkg::REQ_DESTROY, 0, 0);
    push_req(fspa_pkg::REQ_INIT, 8176, 0);           // full budget
    push_req(fspa_pkg::REQ_INIT, 1022, 0);           // rebuild while alive
    push_req(fspa_pkg::REQ_DESTROY, 0, 0);
    drain();

    write_reg(fspa_pkg::CFG_SPP, 2);
    write_reg(fspa_pkg::CFG_BUDGET, 2);
    push_req(fspa_pkg::REQ_INIT, 3, 0);
    repeat (5) push_req(fspa_pkg::REQ_ALLOC, 0, 0);  // fill, then fail growth
    push_req(fspa_pkg::REQ_FREE, 0, 513);
    push_req(fspa_pkg::REQ_FREE, 0, 1);
    drain();

    write_reg(fspa_pkg::CFG_SPP, 0);
    push_req(fspa_pkg::REQ_INIT, 5, 0);
    drain();
    write_reg(fspa_pkg::CFG_SPP, 1);
    write_reg(fspa_pkg::CFG_BUDGET, 31);             // saturates to the maximum
    push_req(fspa_pkg::REQ_INIT, 0, 0);
    random_phase(150);
    drain();

    write_reg(fspa_pkg::CFG_SPP, 3);
    write_reg(fspa_pkg::CFG_BUDGET, 4);
    push_req(fspa_pkg::REQ_INIT, 7, 0);
    no_idle = 1;
    random_phase(150);
    start_hold = 1;                                  // receiver backs up the core
    drain();
    no_idle = 0;

    write_reg(fspa_pkg::CFG_SPP, 13);
    write_reg(fspa_pkg::CFG_BUDGET, 1);
    push_req(fspa_pkg::REQ_INIT, 13, 0);
    random_phase(150);
    drain();

    write_reg(fspa_pkg::CFG_SPP, 511);
    write_reg(fspa_pkg::CFG_BUDGET, 16);
    push_req(fspa_pkg::REQ_INIT, 600, 0);
    random_phase(150);
    drain();
    done = 1;

    $display("Covered %0d requests and %0d results over several page sizes and budgets,",
             n_in, n_out);
    $display("including page growth, budget exhaustion, bad frees and a long output stall.");
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/fspa_pkg.sv
rtl/core/fspa_ram.sv
rtl/core/fspa_divider.sv
rtl/core/fspa_page_walker.sv
rtl/core/fixed_slot_pool_allocator_core.sv
dv/tb_fixed_slot_pool_allocator_core.sv
